### sv/accel_motion_detector_ema_top_macros.svh
// assertion macros for the motion detector
`ifndef ACCEL_MOTION_DETECTOR_EMA_TOP_MACROS_SVH
`define ACCEL_MOTION_DETECTOR_EMA_TOP_MACROS_SVH

// same-cycle implication, clocked on clk and quiet while rst_n is low
`define AMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/amd_pkg.sv
// shared types and constants for the motion detector
package amd_pkg;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int DIST_W = 25;
  localparam int THR_W  = 25;
  localparam int DIV_W  = 8;

  localparam logic [THR_W-1:0] THR_RESET = 25'd256000;
  localparam logic [DIV_W-1:0] DIV_RESET = 8'd8;

  // register index, taken from paddr[2]
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_DIVISOR   = 1'b1;

  localparam logic KIND_CLEAR = 1'b1;

  localparam logic [1:0] AXIS_FIRST = 2'd0;
  localparam logic [1:0] AXIS_LAST  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_AVG,
    ST_SQ,
    ST_ROOT,
    ST_FLAG,
    ST_DONE
  } state_t;

endpackage

### sv/accel_motion_detector_ema_top.sv
// motion detector top level: averaging baseline, distance and motion latch
// A sample item (kind 0) updates the three per-axis moving averages, then
// measures the distance from the sample to the new averages and compares it
// with the threshold register; a kind 1 item clears the motion latch. Every item
// gives exactly one result item. One item is worked at a time and in_stall is
// high until its result has been handed to the output register. A clear item
// or the seeding first sample goes straight to the output state. A later sample
// runs per axis a multiply, SAMPLE_BITS+FRACTION_BITS+8 restoring divide steps
// and a write-back, then a square-and-accumulate per axis through the same
// multiplier, SAMPLE_BITS+FRACTION_BITS+1 square root steps through the same
// subtractor as the divide, a compare and the output register load. The divide
// and the square root retire one bit per cycle. The next item is taken in the
// cycle after the result is registered.
`include "accel_motion_detector_ema_top_macros.svh"

module accel_motion_detector_ema_top #(
  parameter int FRACTION_BITS = 8,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic signed [SAMPLE_BITS-1:0]     in_accel_x,
  input  logic signed [SAMPLE_BITS-1:0]     in_accel_y,
  input  logic signed [SAMPLE_BITS-1:0]     in_accel_z,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [amd_pkg::DIST_W-1:0]        out_distance,
  output logic                              out_moving,
  output logic                              out_motion_latched,
  output logic                              out_seeded,

  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [amd_pkg::ADDR_W-1:0]        paddr,
  input  logic [amd_pkg::DATA_W-1:0]        pwdata,
  output logic [amd_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  localparam int AW   = SAMPLE_BITS + FRACTION_BITS;  // average width
  localparam int DW   = AW + 1;                       // difference width
  localparam int MW   = AW + 2;                       // multiplier operand width
  localparam int PW   = 2 * MW;                       // product width
  localparam int NUMW = AW + amd_pkg::DIV_W;          // dividend magnitude width
  localparam int RW   = AW + 1;                       // root width
  localparam int SUMW = 2 * RW;                       // sum of squares width
  localparam int SUBW = RW + 3;                       // shared subtractor width
  localparam int CNTW = $clog2(NUMW);

  amd_pkg::state_t state_r, state_nxt;

  logic [1:0]                   axis_r, axis_nxt;
  logic [CNTW-1:0]              cnt_r, cnt_nxt;
  logic                         seeded_r, seeded_nxt;
  logic                         moving_r, moving_nxt;
  logic                         latch_r, latch_nxt;
  logic [amd_pkg::DIST_W-1:0]   last_distance_r, last_distance_nxt;
  logic [amd_pkg::THR_W-1:0]    threshold_r, threshold_nxt;
  logic [amd_pkg::DIV_W-1:0]    divisor_r, divisor_nxt;

  logic signed [AW-1:0]         samp_r [3];
  logic signed [AW-1:0]         samp_nxt [3];
  logic signed [AW-1:0]         avg_r [3];
  logic signed [AW-1:0]         avg_nxt [3];
  logic [NUMW-1:0]              num_r, num_nxt;
  logic                         neg_r, neg_nxt;
  logic [RW:0]                  rem_r, rem_nxt;
  logic [SUMW-1:0]              sum_r, sum_nxt;
  logic [RW-1:0]                root_r, root_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [amd_pkg::DIST_W-1:0]   out_distance_r, out_distance_nxt;
  logic                         out_moving_r, out_moving_nxt;
  logic                         out_latched_r, out_latched_nxt;
  logic                         out_seeded_r, out_seeded_nxt;

  logic                         in_accept;
  logic                         cfg_write;
  logic [amd_pkg::DIV_W-1:0]    alpha_eff;
  logic [amd_pkg::DIV_W-1:0]    alpha_m1;
  logic signed [AW-1:0]         scaled_x, scaled_y, scaled_z;

  // shared multiplier
  logic signed [MW-1:0]         mul_a, mul_b;
  logic signed [PW-1:0]         prod;
  logic signed [PW-1:0]         num_full;
  logic signed [PW-1:0]         num_abs;
  logic signed [DW-1:0]         diff_d;
  logic signed [NUMW:0]         q_signed;

  // shared subtract and compare
  logic [SUBW-1:0]              sub_a, sub_b;
  logic [SUBW:0]                sub_d;
  logic                         sub_ge;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != amd_pkg::ST_IDLE);
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  assign alpha_eff = (divisor_r == '0) ? amd_pkg::DIV_W'(1) : divisor_r;
  assign alpha_m1  = alpha_eff - amd_pkg::DIV_W'(1);

  assign scaled_x = AW'(in_accel_x) <<< FRACTION_BITS;
  assign scaled_y = AW'(in_accel_y) <<< FRACTION_BITS;
  assign scaled_z = AW'(in_accel_z) <<< FRACTION_BITS;

  assign diff_d   = DW'(samp_r[axis_r]) - DW'(avg_r[axis_r]);
  assign prod     = mul_a * mul_b;
  assign num_full = prod + PW'(samp_r[axis_r]);
  assign num_abs  = num_full[PW-1] ? -num_full : num_full;
  assign q_signed = neg_r ? -$signed({1'b0, num_r}) : $signed({1'b0, num_r});

  assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge = ~sub_d[SUBW];

  // operand selection for the shared units
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    sub_a = '0;
    sub_b = '0;
    case (state_r)
      amd_pkg::ST_MUL: begin
        mul_a = MW'(avg_r[axis_r]);
        mul_b = MW'(alpha_m1);
      end
      amd_pkg::ST_SQ: begin
        mul_a = MW'(diff_d);
        mul_b = MW'(diff_d);
      end
      amd_pkg::ST_DIV: begin
        sub_a = SUBW'({rem_r[RW-1:0], num_r[NUMW-1]});
        sub_b = SUBW'(alpha_eff);
      end
      amd_pkg::ST_ROOT: begin
        sub_a = {rem_r, sum_r[SUMW-1 -: 2]};
        sub_b = SUBW'({root_r, 2'b01});
      end
      default: begin
      end
    endcase
  end

  // configuration read
  always_comb begin
    case (paddr[2])
      amd_pkg::REG_THRESHOLD: prdata = amd_pkg::DATA_W'(threshold_r);
      amd_pkg::REG_DIVISOR:   prdata = amd_pkg::DATA_W'(divisor_r);
      default:                prdata = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt         = state_r;
    axis_nxt          = axis_r;
    cnt_nxt           = cnt_r;
    seeded_nxt        = seeded_r;
    moving_nxt        = moving_r;
    latch_nxt         = latch_r;
    last_distance_nxt = last_distance_r;
    threshold_nxt     = threshold_r;
    divisor_nxt       = divisor_r;
    samp_nxt          = samp_r;
    avg_nxt           = avg_r;
    num_nxt           = num_r;
    neg_nxt           = neg_r;
    rem_nxt           = rem_r;
    sum_nxt           = sum_r;
    root_nxt          = root_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_distance_nxt  = out_distance_r;
    out_moving_nxt    = out_moving_r;
    out_latched_nxt   = out_latched_r;
    out_seeded_nxt    = out_seeded_r;

    if (cfg_write) begin
      case (paddr[2])
        amd_pkg::REG_THRESHOLD: threshold_nxt = pwdata[amd_pkg::THR_W-1:0];
        amd_pkg::REG_DIVISOR:   divisor_nxt   = pwdata[amd_pkg::DIV_W-1:0];
        default: begin
        end
      endcase
    end

    case (state_r)
      amd_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_kind == amd_pkg::KIND_CLEAR) begin
            latch_nxt = 1'b0;
            state_nxt = amd_pkg::ST_DONE;
          end else begin
            samp_nxt[0] = scaled_x;
            samp_nxt[1] = scaled_y;
            samp_nxt[2] = scaled_z;
            if (!seeded_r) begin
              avg_nxt[0] = scaled_x;
              avg_nxt[1] = scaled_y;
              avg_nxt[2] = scaled_z;
              seeded_nxt = 1'b1;
              moving_nxt = 1'b0;
              state_nxt  = amd_pkg::ST_DONE;
            end else begin
              axis_nxt  = amd_pkg::AXIS_FIRST;
              state_nxt = amd_pkg::ST_MUL;
            end
          end
        end
      end
      amd_pkg::ST_MUL: begin
        // numerator avg*(alpha-1)+sample, kept as sign and magnitude
        num_nxt   = num_abs[NUMW-1:0];
        neg_nxt   = num_full[PW-1];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = amd_pkg::ST_DIV;
      end
      amd_pkg::ST_DIV: begin
        // restoring divide, quotient bits shift in behind the dividend
        rem_nxt = sub_ge ? sub_d[RW:0] : sub_a[RW:0];
        num_nxt = {num_r[NUMW-2:0], sub_ge};
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(NUMW - 1)) begin
          state_nxt = amd_pkg::ST_AVG;
        end
      end
      amd_pkg::ST_AVG: begin
        avg_nxt[axis_r] = q_signed[AW-1:0];
        if (axis_r == amd_pkg::AXIS_LAST) begin
          axis_nxt  = amd_pkg::AXIS_FIRST;
          sum_nxt   = '0;
          state_nxt = amd_pkg::ST_SQ;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = amd_pkg::ST_MUL;
        end
      end
      amd_pkg::ST_SQ: begin
        sum_nxt = sum_r + prod[SUMW-1:0];
        if (axis_r == amd_pkg::AXIS_LAST) begin
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = amd_pkg::ST_ROOT;
        end else begin
          axis_nxt = axis_r + 2'd1;
        end
      end
      amd_pkg::ST_ROOT: begin
        // two radicand bits per step, one root bit out
        rem_nxt  = sub_ge ? sub_d[RW:0] : sub_a[RW:0];
        root_nxt = {root_r[RW-2:0], sub_ge};
        sum_nxt  = sum_r << 2;
        cnt_nxt  = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(RW - 1)) begin
          last_distance_nxt = amd_pkg::DIST_W'(root_nxt);
          state_nxt         = amd_pkg::ST_FLAG;
        end
      end
      amd_pkg::ST_FLAG: begin
        moving_nxt = (last_distance_r > threshold_r);
        if (last_distance_r > threshold_r) begin
          latch_nxt = 1'b1;
        end
        state_nxt = amd_pkg::ST_DONE;
      end
      amd_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt    = 1'b1;
          out_distance_nxt = last_distance_r;
          out_moving_nxt   = moving_r;
          out_latched_nxt  = latch_r;
          out_seeded_nxt   = seeded_r;
          state_nxt        = amd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = amd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= amd_pkg::ST_IDLE;
      axis_r          <= amd_pkg::AXIS_FIRST;
      cnt_r           <= '0;
      seeded_r        <= 1'b0;
      moving_r        <= 1'b0;
      latch_r         <= 1'b0;
      last_distance_r <= '0;
      threshold_r     <= amd_pkg::THR_RESET;
      divisor_r       <= amd_pkg::DIV_RESET;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      axis_r          <= axis_nxt;
      cnt_r           <= cnt_nxt;
      seeded_r        <= seeded_nxt;
      moving_r        <= moving_nxt;
      latch_r         <= latch_nxt;
      last_distance_r <= last_distance_nxt;
      threshold_r     <= threshold_nxt;
      divisor_r       <= divisor_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    samp_r         <= samp_nxt;
    avg_r          <= avg_nxt;
    num_r          <= num_nxt;
    neg_r          <= neg_nxt;
    rem_r          <= rem_nxt;
    sum_r          <= sum_nxt;
    root_r         <= root_nxt;
    out_distance_r <= out_distance_nxt;
    out_moving_r   <= out_moving_nxt;
    out_latched_r  <= out_latched_nxt;
    out_seeded_r   <= out_seeded_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_distance       = out_distance_r;
  assign out_moving         = out_moving_r;
  assign out_motion_latched = out_latched_r;
  assign out_seeded         = out_seeded_r;

  `AMD_ASSERT_NOW(a_update_after_seed, (state_r == amd_pkg::ST_MUL), seeded_r,
    "average update before seeding")
  `AMD_ASSERT_NOW(a_div_rem_bound, (state_r == amd_pkg::ST_DIV),
    (rem_r < (RW+1)'(alpha_eff)), "divide remainder not below divisor")
  `AMD_ASSERT_NOW(a_root_rem_bound, (state_r == amd_pkg::ST_ROOT),
    (rem_r <= ({root_r, 1'b0})), "root remainder above twice the root")
  `AMD_ASSERT_NEXT(a_accept_busy, in_accept, (state_r != amd_pkg::ST_IDLE),
    "accepted item left the sequencer idle")
  `AMD_ASSERT_NEXT(a_latch_on_motion,
    ((state_r == amd_pkg::ST_FLAG) && (last_distance_r > threshold_r)), latch_r,
    "motion did not set the latch")

endmodule
